### sv/assert_macros.svh
// Assertion macros shared by the link rank RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LRI_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Concurrent assertion on the house clock clk_i and reset rst_ni.
`define LRI_ASSERT(label, prop, msg) \
  `LRI_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### sv/lri_pkg.sv
// Package with the types, constants and register codes of the link rank block.
package lri_pkg;

  localparam int unsigned MAX_PAGES   = 64;
  localparam int unsigned RANK_FRAC   = 24;
  localparam int unsigned ROW_W       = 64;
  localparam int unsigned PAGE_W      = 6;
  localparam int unsigned RANK_W      = 32;
  localparam int unsigned NODE_W      = 7;
  localparam int unsigned DAMP_W      = 16;
  localparam int unsigned TOL_W       = 16;
  localparam int unsigned SWEEP_W     = 16;
  localparam int unsigned ADDR_W      = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W       = $clog2(MAX_PAGES + 1);
  localparam int unsigned DEG_W       = $clog2(MAX_PAGES + 1);
  localparam int unsigned PROD_W      = DAMP_W + RANK_W;
  localparam int unsigned ACC_W       = PROD_W + ADDR_W + 1;
  localparam int unsigned DIV_STEP    = 4;
  localparam int unsigned DIV_CYCLES  = PROD_W / DIV_STEP;
  localparam int unsigned DIVC_W      = $clog2(DIV_CYCLES + 1);
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SWEEPS = 2'd3;

  localparam logic [NODE_W-1:0]  RST_NODE_COUNT = 7'd64;
  localparam logic [DAMP_W-1:0]  RST_DAMPING    = 16'd55706;
  localparam logic [TOL_W-1:0]   RST_TOLERANCE  = 16'd17;
  localparam logic [SWEEP_W-1:0] RST_MAX_SWEEPS = 16'd1000;

  typedef struct packed {
    logic [ROW_W-1:0] row_links;
    logic             last_row;
  } lri_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic [RANK_W-1:0] rank;
    logic              converged;
    logic              last_page;
  } lri_out_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_count;
    logic [DAMP_W-1:0]  damping;
    logic [TOL_W-1:0]   tolerance;
    logic [SWEEP_W-1:0] max_sweeps;
  } lri_cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEG_W-1:0]  divisor;
  } lri_div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } lri_div_rsp_t;

endpackage

### sv/link_rank_iteration.sv
// Top level of the link rank block: configuration registers and the rank core.
//
// Channel   Dir      Handshake                              Payload
// config    in/out   psel, penable, pwrite, pready          paddr, pwdata, prdata
// rows      in       start && !busy                         row_i (lri_in_t)
// results   out      res_strobe_o, one cycle each           res_o (lri_out_t)
//
// Rows are taken one per cycle while the block is idle; the row marked last starts a run.
// A run first clears the degree and rank memories and counts the degree of each page, then
// sweeps over the pages with the shared divider, which retires four quotient bits a cycle,
// and finally sends one result per page, one per cycle.
// Reset clears the control state and loads the register reset values; the link, degree and
// rank memories are not cleared by reset. Results cannot be stalled by the receiver.
module link_rank_iteration (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lri_pkg::APB_AW-1:0]    paddr,
  input  logic [lri_pkg::APB_DW-1:0]    pwdata,
  output logic [lri_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  lri_pkg::lri_in_t              row_i,
  output logic                          res_strobe_o,
  output lri_pkg::lri_out_t             res_o
);
  import lri_pkg::*;

  logic [NODE_W-1:0]    node_count_q;
  logic [DAMP_W-1:0]    damping_q;
  logic [TOL_W-1:0]     tolerance_q;
  logic [SWEEP_W-1:0]   max_sweeps_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;
  lri_cfg_t             cfg;

  // Registers sit on 32-bit words, so the word index is the address above bit one.
  assign reg_idx   = paddr[APB_AW-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= RST_NODE_COUNT;
      damping_q    <= RST_DAMPING;
      tolerance_q  <= RST_TOLERANCE;
      max_sweeps_q <= RST_MAX_SWEEPS;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_NODE_COUNT: node_count_q <= pwdata[NODE_W-1:0];
        REG_DAMPING:    damping_q    <= pwdata[DAMP_W-1:0];
        REG_TOLERANCE:  tolerance_q  <= pwdata[TOL_W-1:0];
        REG_MAX_SWEEPS: max_sweeps_q <= pwdata[SWEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the stored value, zero-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT: prdata = APB_DW'(node_count_q);
      REG_DAMPING:    prdata = APB_DW'(damping_q);
      REG_TOLERANCE:  prdata = APB_DW'(tolerance_q);
      REG_MAX_SWEEPS: prdata = APB_DW'(max_sweeps_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg.node_count = node_count_q;
  assign cfg.damping    = damping_q;
  assign cfg.tolerance  = tolerance_q;
  assign cfg.max_sweeps = max_sweeps_q;

  // The core owns the whole run; busy drops only once the last result is in flight.
  lri_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (start),
    .in_i       (row_i),
    .busy_o     (busy),
    .res_vld_o  (res_strobe_o),
    .res_o      (res_o)
  );

endmodule

### sv/lri_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module lri_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/lri_div.sv
// Shared multi-cycle restoring divider for the per-link rank share.
`include "assert_macros.svh"

module lri_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lri_pkg::lri_div_req_t req_i,
  output lri_pkg::lri_div_rsp_t rsp_o
);
  import lri_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DEG_W-1:0]  rem_q, rem_d;
  logic [DEG_W-1:0]  div_q, div_d;
  logic [PROD_W-1:0] quo_step;
  logic [DEG_W-1:0]  rem_step;
  logic [DEG_W:0]    trial;

  // Several quotient bits per cycle; the remainder stays below the divisor.
  always_comb begin
    quo_step = quo_q;
    rem_step = rem_q;
    trial    = '0;
    for (int s = 0; s < DIV_STEP; s++) begin
      trial    = {rem_step, quo_step[PROD_W-1]};
      quo_step = {quo_step[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial       = trial - {1'b0, div_q};
        quo_step[0] = 1'b1;
      end
      rem_step = trial[DEG_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIVC_W'(DIV_CYCLES);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = quo_step;
      rem_d = rem_step;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIVC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `LRI_ASSERT(a_div_start_idle, req_i.start |-> !busy_q, "divider started while busy")
  `LRI_ASSERT(a_div_rem_range, done_q |-> (rem_q < div_q), "divider remainder not below divisor")

endmodule

### sv/lri_core.sv
// Sequencer of the link rank block: row load, degree count, sweeps and result output.
`include "assert_macros.svh"

module lri_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lri_pkg::lri_cfg_t cfg_i,
  input  logic              in_valid_i,
  input  lri_pkg::lri_in_t  in_i,
  output logic              busy_o,
  output logic              res_vld_o,
  output lri_pkg::lri_out_t res_o
);
  import lri_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_CROW  = 4'd2;
  localparam logic [3:0] S_CROWW = 4'd3;
  localparam logic [3:0] S_CSCAN = 4'd4;
  localparam logic [3:0] S_CINC  = 4'd5;
  localparam logic [3:0] S_ROW   = 4'd6;
  localparam logic [3:0] S_ROWW  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OLD   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_DRAIN = 4'd13;

  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   i_q, i_d, j_q, j_d, row_cnt_q, row_cnt_d;
  logic [SWEEP_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic               settled_q, settled_d, conv_q, conv_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               pend_q, pend_d, plast_q, plast_d;
  logic [PAGE_W-1:0]  pidx_q, pidx_d;
  logic               res_vld_q;
  lri_out_t           res_q;

  logic [CNT_W-1:0]   n_pages, i_inc, j_inc;
  logic               i_last, j_end, accept;
  logic [ADDR_W-1:0]  i_addr, j_addr;
  logic [ROW_W-1:0]   col_mask;
  logic [SWEEP_W-1:0] cap;
  logic [SWEEP_W:0]   sweep_inc;
  logic [DAMP_W:0]    damp_comp;
  logic [ACC_W-1:0]   base;
  logic [RANK_W-1:0]  new_rank, rank_diff;
  logic               diff_ok;

  logic               m_we;
  logic [ROW_W-1:0]   m_rdata;
  logic               d_we;
  logic [DEG_W-1:0]   d_wdata, d_rdata;
  logic               r_we;
  logic [ADDR_W-1:0]  r_waddr, r_raddr;
  logic [RANK_W-1:0]  r_wdata, r_rdata;
  lri_div_req_t       div_req;
  lri_div_rsp_t       div_rsp;

  always_comb begin
    if (cfg_i.node_count == '0) begin
      n_pages = CNT_W'(1);
    end else if (cfg_i.node_count > NODE_W'(MAX_PAGES)) begin
      n_pages = CNT_W'(MAX_PAGES);
    end else begin
      n_pages = CNT_W'(cfg_i.node_count);
    end
  end

  assign col_mask  = (int'(n_pages) >= ROW_W) ? '1 : ((ROW_W'(1) << n_pages) - ROW_W'(1));
  assign cap       = (cfg_i.max_sweeps == '0) ? SWEEP_W'(1) : cfg_i.max_sweeps;
  assign sweep_inc = {1'b0, sweep_cnt_q} + 1'b1;
  assign i_inc     = i_q + 1'b1;
  assign j_inc     = j_q + 1'b1;
  assign i_last    = (i_inc == n_pages);
  assign j_end     = (j_q == n_pages);
  assign i_addr    = i_q[ADDR_W-1:0];
  assign j_addr    = j_q[ADDR_W-1:0];
  assign accept    = in_valid_i && (state_q == S_IDLE);

  // The (1-d) term once per page, scaled to the accumulator's Q.40 format.
  assign damp_comp = {1'b1, {DAMP_W{1'b0}}} - {1'b0, cfg_i.damping};
  assign base      = ACC_W'(damp_comp) << RANK_FRAC;

  assign new_rank  = (|acc_q[ACC_W-1:RANK_W+DAMP_W]) ? '1 : acc_q[RANK_W+DAMP_W-1:DAMP_W];
  assign rank_diff = (new_rank > r_rdata) ? (new_rank - r_rdata) : (r_rdata - new_rank);
  assign diff_ok   = (rank_diff <= RANK_W'(cfg_i.tolerance));

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    row_cnt_d   = row_cnt_q;
    sweep_cnt_d = sweep_cnt_q;
    settled_d   = settled_q;
    conv_d      = conv_q;
    row_d       = row_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    pidx_d      = PAGE_W'(i_q);
    plast_d     = i_last;
    m_we        = 1'b0;
    d_we        = 1'b0;
    d_wdata     = '0;
    r_we        = 1'b0;
    r_wdata     = '0;
    r_waddr     = j_addr;
    r_raddr     = j_addr;
    div_req.start    = 1'b0;
    div_req.dividend = PROD_W'(cfg_i.damping) * PROD_W'(r_rdata);
    div_req.divisor  = d_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (row_cnt_q < n_pages) begin
            m_we      = 1'b1;
            row_cnt_d = row_cnt_q + 1'b1;
          end
          if (in_i.last_row) begin
            row_cnt_d = '0;
            j_d       = '0;
            state_d   = S_CLR;
          end
        end
      end
      S_CLR: begin
        d_we = 1'b1;
        r_we = 1'b1;
        j_d  = j_inc;
        if (j_inc == n_pages) begin
          j_d     = '0;
          i_d     = '0;
          state_d = S_CROW;
        end
      end
      S_CROW: begin
        state_d = S_CROWW;
      end
      S_CROWW: begin
        row_d   = m_rdata;
        j_d     = '0;
        state_d = S_CSCAN;
      end
      S_CSCAN: begin
        if (j_end) begin
          i_d     = i_inc;
          state_d = S_CROW;
          if (i_last) begin
            i_d         = '0;
            sweep_cnt_d = '0;
            settled_d   = 1'b1;
            state_d     = S_ROW;
          end
        end else if (row_q[j_addr]) begin
          state_d = S_CINC;
        end else begin
          j_d = j_inc;
        end
      end
      S_CINC: begin
        d_we    = 1'b1;
        d_wdata = DEG_W'(d_rdata + 1'b1);
        j_d     = j_inc;
        state_d = S_CSCAN;
      end
      S_ROW: begin
        state_d = S_ROWW;
      end
      S_ROWW: begin
        row_d   = m_rdata & col_mask;
        acc_d   = base;
        j_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_end) begin
          r_raddr = i_addr;
          state_d = S_OLD;
        end else if (row_q[j_addr]) begin
          state_d = S_MUL;
        end else begin
          j_d = j_inc;
        end
      end
      S_MUL: begin
        if (d_rdata == '0) begin
          j_d     = j_inc;
          state_d = S_SCAN;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          acc_d   = acc_q + ACC_W'(div_rsp.quotient);
          j_d     = j_inc;
          state_d = S_SCAN;
        end
      end
      S_OLD: begin
        r_we      = 1'b1;
        r_waddr   = i_addr;
        r_wdata   = new_rank;
        settled_d = settled_q && diff_ok;
        i_d       = i_inc;
        state_d   = S_ROW;
        if (i_last) begin
          i_d         = '0;
          sweep_cnt_d = sweep_inc[SWEEP_W-1:0];
          settled_d   = 1'b1;
          if (settled_q && diff_ok) begin
            conv_d  = 1'b1;
            state_d = S_OUT;
          end else if (sweep_inc >= {1'b0, cap}) begin
            conv_d  = 1'b0;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        r_raddr = i_addr;
        pend_d  = 1'b1;
        i_d     = i_inc;
        if (i_last) begin
          i_d     = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      row_cnt_q   <= '0;
      sweep_cnt_q <= '0;
      settled_q   <= 1'b0;
      conv_q      <= 1'b0;
      pend_q      <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      row_cnt_q   <= row_cnt_d;
      sweep_cnt_q <= sweep_cnt_d;
      settled_q   <= settled_d;
      conv_q      <= conv_d;
      pend_q      <= pend_d;
      res_vld_q   <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q            <= row_d;
    acc_q            <= acc_d;
    pidx_q           <= pidx_d;
    plast_q          <= plast_d;
    res_q.page_index <= pidx_q;
    res_q.rank       <= r_rdata;
    res_q.converged  <= conv_q;
    res_q.last_page  <= plast_q;
  end

  lri_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_PAGES)
  ) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (row_cnt_q[ADDR_W-1:0]),
    .wdata_i (in_i.row_links),
    .raddr_i (i_addr),
    .rdata_o (m_rdata)
  );

  lri_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_PAGES)
  ) u_degree_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (j_addr),
    .wdata_i (d_wdata),
    .raddr_i (j_addr),
    .rdata_o (d_rdata)
  );

  lri_ram #(
    .WIDTH (RANK_W),
    .DEPTH (MAX_PAGES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  lri_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy_o    = (state_q != S_IDLE);
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

  `LRI_ASSERT(a_core_page_order, (res_vld_q && $past(res_vld_q)) |-> (res_q.page_index == PAGE_W'($past(res_q.page_index) + 1'b1)), "pages out of order")
  `LRI_ASSERT(a_core_last_page, (res_vld_q && res_q.last_page) |=> !res_vld_q, "result after last page")

endmodule
